@@ design/hdd_pkg.sv @@
// Shared types and constants for the hover dwell detector.
package hdd_pkg;

   localparam int POS_WIDTH     = 16;
   localparam int TIME_WIDTH    = 16;
   localparam int DWELL_WIDTH   = 24;
   localparam int RADIUS_WIDTH  = 16;
   localparam int RSQ_WIDTH     = 2 * RADIUS_WIDTH;
   localparam int DIST_WIDTH    = 2 * POS_WIDTH + 1;
   localparam int CSR_IDX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = DWELL_WIDTH;

   localparam logic [DWELL_WIDTH-1:0]  DWELL_MAX      = {DWELL_WIDTH{1'b1}};
   localparam logic [DWELL_WIDTH-1:0]  DWELL_RESET    = DWELL_WIDTH'(500);
   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET   = RADIUS_WIDTH'(5);

   typedef enum logic [1:0] {
      ACT_MOVE    = 2'd0,
      ACT_PRESS   = 2'd1,
      ACT_RELEASE = 2'd2,
      ACT_OTHER   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_REQUIRED_DWELL = 2'd0,
      CSR_RADIUS         = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [DWELL_WIDTH-1:0] required_dwell;
      logic [RSQ_WIDTH-1:0]   radius_sq;
   } cfg_type;

endpackage

@@ design/hdd_csr.sv @@
// Configuration registers: required dwell time and squared tolerance radius.
module hdd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [hdd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [hdd_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output hdd_pkg::cfg_type                    cfg
);

   logic [hdd_pkg::DWELL_WIDTH-1:0]  required_ff, required_in;
   logic [hdd_pkg::RSQ_WIDTH-1:0]    radius_sq_ff, radius_sq_in;
   logic [hdd_pkg::RADIUS_WIDTH-1:0] radius_wr;

   assign radius_wr = csr_data[hdd_pkg::RADIUS_WIDTH-1:0];

   always_comb begin
      required_in  = required_ff;
      radius_sq_in = radius_sq_ff;
      if (csr_valid) begin
         case (csr_index)
            hdd_pkg::CSR_REQUIRED_DWELL: required_in = csr_data[hdd_pkg::DWELL_WIDTH-1:0];
            hdd_pkg::CSR_RADIUS: begin
               radius_sq_in = hdd_pkg::RSQ_WIDTH'(radius_wr) * hdd_pkg::RSQ_WIDTH'(radius_wr);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff  <= hdd_pkg::DWELL_RESET;
         radius_sq_ff <= hdd_pkg::RSQ_WIDTH'(hdd_pkg::RADIUS_RESET)
                         * hdd_pkg::RSQ_WIDTH'(hdd_pkg::RADIUS_RESET);
      end else begin
         required_ff  <= required_in;
         radius_sq_ff <= radius_sq_in;
      end
   end

   assign cfg.required_dwell = required_ff;
   assign cfg.radius_sq      = radius_sq_ff;

endmodule

@@ design/hdd_core.sv @@
// Tracking state, anchor distance check and saturating dwell accumulation.
module hdd_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  hdd_pkg::action_type              action,
   input  logic [hdd_pkg::POS_WIDTH-1:0]    pos_x,
   input  logic [hdd_pkg::POS_WIDTH-1:0]    pos_y,
   input  logic [hdd_pkg::TIME_WIDTH-1:0]   elapsed_ms,
   input  hdd_pkg::cfg_type                 cfg,
   output logic                             confirmed
);

   logic                              tracking_ff, tracking_in;
   logic [hdd_pkg::POS_WIDTH-1:0]     anchor_x_ff, anchor_x_in;
   logic [hdd_pkg::POS_WIDTH-1:0]     anchor_y_ff, anchor_y_in;
   logic [hdd_pkg::DWELL_WIDTH-1:0]   dwell_ff, dwell_in;

   logic signed [hdd_pkg::POS_WIDTH:0] dx, dy;
   logic [hdd_pkg::POS_WIDTH-1:0]      abs_dx, abs_dy;
   logic [hdd_pkg::DIST_WIDTH-1:0]     dist_sq;
   logic [hdd_pkg::DWELL_WIDTH:0]      dwell_sum;
   logic [hdd_pkg::DWELL_WIDTH-1:0]    dwell_sat;
   logic                               outside;

   always_comb begin
      dx = {pos_x[hdd_pkg::POS_WIDTH-1], pos_x} - {anchor_x_ff[hdd_pkg::POS_WIDTH-1], anchor_x_ff};
      dy = {pos_y[hdd_pkg::POS_WIDTH-1], pos_y} - {anchor_y_ff[hdd_pkg::POS_WIDTH-1], anchor_y_ff};
      abs_dx = dx[hdd_pkg::POS_WIDTH] ? hdd_pkg::POS_WIDTH'(-dx) : dx[hdd_pkg::POS_WIDTH-1:0];
      abs_dy = dy[hdd_pkg::POS_WIDTH] ? hdd_pkg::POS_WIDTH'(-dy) : dy[hdd_pkg::POS_WIDTH-1:0];
      dist_sq = hdd_pkg::DIST_WIDTH'(abs_dx) * hdd_pkg::DIST_WIDTH'(abs_dx)
              + hdd_pkg::DIST_WIDTH'(abs_dy) * hdd_pkg::DIST_WIDTH'(abs_dy);
      outside = dist_sq > hdd_pkg::DIST_WIDTH'(cfg.radius_sq);
      dwell_sum = {1'b0, dwell_ff} + (hdd_pkg::DWELL_WIDTH + 1)'(elapsed_ms);
      dwell_sat = dwell_sum[hdd_pkg::DWELL_WIDTH] ? hdd_pkg::DWELL_MAX
                                                  : dwell_sum[hdd_pkg::DWELL_WIDTH-1:0];
   end

   always_comb begin
      tracking_in = tracking_ff;
      anchor_x_in = anchor_x_ff;
      anchor_y_in = anchor_y_ff;
      dwell_in    = dwell_ff;
      confirmed   = 1'b0;
      if (action inside {hdd_pkg::ACT_PRESS, hdd_pkg::ACT_RELEASE}) begin
         tracking_in = 1'b0;
         dwell_in    = '0;
      end else if (action == hdd_pkg::ACT_MOVE && (!tracking_ff || outside)) begin
         tracking_in = 1'b1;
         anchor_x_in = pos_x;
         anchor_y_in = pos_y;
         dwell_in    = '0;
      end else if (tracking_ff) begin
         dwell_in  = dwell_sat;
         confirmed = dwell_sat >= cfg.required_dwell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracking_ff <= 1'b0;
         anchor_x_ff <= '0;
         anchor_y_ff <= '0;
         dwell_ff    <= '0;
      end else if (step) begin
         tracking_ff <= tracking_in;
         anchor_x_ff <= anchor_x_in;
         anchor_y_ff <= anchor_y_in;
         dwell_ff    <= dwell_in;
      end
   end

endmodule

@@ design/hover_dwell_detector_top.sv @@
// Top level of the hover dwell detector: input register, core and result register.
// The req_ channel takes one pointer event per beat: action, pos_x, pos_y and
// elapsed_ms. A beat moves when req_valid is high and req_stall is low.
// Every event yields exactly one rsp_ beat carrying confirmed, in event order.
// The csr_ channel writes required_dwell_ms (index 0) and radius_px (index 1);
// csr_ready is always high and other indexes are ignored. Write only while idle.
// A beat accepted into the input register moves into the result register and shows
// its result on rsp_valid when the result register is free.
// Throughput is one event per cycle while rsp_stall is low; the state update
// and the distance and dwell compare are combinational between the two registers.
// When the receiver holds rsp_stall, the result register holds and one more
// event may wait in the input register before req_stall rises.
// Reset clears tracking, anchor and dwell, empties both registers and loads
// a required dwell of 500 ms and a radius of 5 pixels.
module hover_dwell_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_action,
   input  logic signed [hdd_pkg::POS_WIDTH-1:0] req_pos_x,
   input  logic signed [hdd_pkg::POS_WIDTH-1:0] req_pos_y,
   input  logic [hdd_pkg::TIME_WIDTH-1:0]      req_elapsed_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_confirmed,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hdd_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [hdd_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   hdd_pkg::cfg_type cfg;

   logic                            in_valid_ff, in_valid_in;
   logic [1:0]                      action_ff;
   logic [hdd_pkg::POS_WIDTH-1:0]   pos_x_ff, pos_y_ff;
   logic [hdd_pkg::TIME_WIDTH-1:0]  elapsed_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            confirmed_ff, confirmed_in;
   logic                            advance, load, step;

   assign csr_ready = 1'b1;

   hdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign step      = in_valid_ff && advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         in_valid_in  = load;
         rsp_valid_in = in_valid_ff;
      end else if (!in_valid_ff) begin
         in_valid_in = load;
      end
   end

   hdd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .action     (hdd_pkg::action_type'(action_ff)),
      .pos_x      (pos_x_ff),
      .pos_y      (pos_y_ff),
      .elapsed_ms (elapsed_ff),
      .cfg        (cfg),
      .confirmed  (confirmed_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff  <= req_action;
         pos_x_ff   <= req_pos_x;
         pos_y_ff   <= req_pos_y;
         elapsed_ff <= req_elapsed_ms;
      end
      if (step) begin
         confirmed_ff <= confirmed_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_confirmed = confirmed_ff;

endmodule

@@ bench/tb_hover_dwell_detector_top.sv @@
// Self-checking testbench for the hover dwell detector: directed and random pointer events.
module tb_hover_dwell_detector_top;
   import hdd_pkg::*;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_UNUSED_HI = 2'd3;
   localparam logic signed [POS_WIDTH-1:0] POS_MIN = 16'sh8000;
   localparam logic signed [POS_WIDTH-1:0] POS_MAX = 16'sh7FFF;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = 16'hFFFF;

   class hover_scoreboard;
      logic [DWELL_WIDTH-1:0]        required_dwell;
      logic [RADIUS_WIDTH-1:0]       radius;
      bit                            tracking;
      logic signed [POS_WIDTH-1:0]   anchor_x;
      logic signed [POS_WIDTH-1:0]   anchor_y;
      logic [DWELL_WIDTH-1:0]        dwell;
      bit                            confirm_q[$];
      int                            errors;
      int                            events;
      int                            confirms;
      int                            saturations;

      function new();
         required_dwell = DWELL_RESET;
         radius         = RADIUS_RESET;
         tracking       = 1'b0;
         anchor_x       = '0;
         anchor_y       = '0;
         dwell          = '0;
         errors         = 0;
         events         = 0;
         confirms       = 0;
         saturations    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_REQUIRED_DWELL: required_dwell = data[DWELL_WIDTH-1:0];
            CSR_RADIUS:         radius = data[RADIUS_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function void note_event(action_type act, logic signed [POS_WIDTH-1:0] x,
                               logic signed [POS_WIDTH-1:0] y, logic [TIME_WIDTH-1:0] dt);
         bit                   hit;
         bit                   add_time;
         longint               dx;
         longint               dy;
         longint               dist_sq;
         longint               radius_sq;
         logic [DWELL_WIDTH:0] sum;
         hit      = 1'b0;
         add_time = 1'b1;
         if (act == ACT_PRESS || act == ACT_RELEASE) begin
            tracking = 1'b0;
            dwell    = '0;
            add_time = 1'b0;
         end else if (act == ACT_MOVE) begin
            dx        = longint'(x) - longint'(anchor_x);
            dy        = longint'(y) - longint'(anchor_y);
            dist_sq   = dx * dx + dy * dy;
            radius_sq = longint'(radius) * longint'(radius);
            if (!tracking || dist_sq > radius_sq) begin
               tracking = 1'b1;
               anchor_x = x;
               anchor_y = y;
               dwell    = '0;
               add_time = 1'b0;
            end
         end
         if (add_time && tracking) begin
            sum = {1'b0, dwell} + (DWELL_WIDTH + 1)'(dt);
            if (sum > {1'b0, DWELL_MAX}) begin
               dwell = DWELL_MAX;
               saturations++;
            end else begin
               dwell = sum[DWELL_WIDTH-1:0];
            end
            hit = (dwell >= required_dwell);
         end
         events++;
         if (hit) begin
            confirms++;
         end
         confirm_q.push_back(hit);
      endfunction

      function void check_result(logic confirmed);
         bit expected;
         if (confirm_q.size() == 0) begin
            $error("confirmed: expected no beat, actual %0b", confirmed);
            errors++;
         end else begin
            expected = confirm_q.pop_front();
            if (confirmed !== expected) begin
               $error("confirmed: expected %0b, actual %0b", expected, confirmed);
               errors++;
            end
         end
      endfunction

      function int pending();
         return confirm_q.size();
      endfunction

      function void report_leftovers();
         if (confirm_q.size() != 0) begin
            $error("confirmed: expected %0d more beats, actual none", confirm_q.size());
            errors += confirm_q.size();
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_action = ACT_OTHER;
   logic signed [POS_WIDTH-1:0]      req_pos_x = '0;
   logic signed [POS_WIDTH-1:0]      req_pos_y = '0;
   logic [TIME_WIDTH-1:0]            req_elapsed_ms = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic                             rsp_confirmed;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [CSR_IDX_WIDTH-1:0]         csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]        csr_data = '0;

   hover_scoreboard sb;
   bit              tx_idle = 1'b1;
   bit              rx_idle = 1'b1;
   int              settings_written = 0;

   hover_dwell_detector_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_elapsed_ms (req_elapsed_ms),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_confirmed  (rsp_confirmed),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever begin
         #10 clock = ~clock;
      end
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_event(input action_type act, input logic signed [POS_WIDTH-1:0] x,
                             input logic signed [POS_WIDTH-1:0] y,
                             input logic [TIME_WIDTH-1:0] dt);
      int gap;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_elapsed_ms <= dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_event(act, x, y, dt);
      gap = tx_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_reg(input logic [CSR_IDX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(index, data);
      settings_written++;
      csr_valid <= 1'b0;
   endtask

   task automatic random_events(input int count, input int dt_cap, input bit saturate);
      action_type                  act;
      logic signed [POS_WIDTH-1:0] x;
      logic signed [POS_WIDTH-1:0] y;
      logic [TIME_WIDTH-1:0]       dt;
      int                          pick;
      int                          span;
      int                          dt_kind;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 149) begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 149) == 0) begin
            wait_idle();
         end
         pick    = $urandom_range(0, 999);
         x       = 16'($urandom);
         y       = 16'($urandom);
         act     = ACT_OTHER;
         span    = int'(sb.radius);
         dt_kind = $urandom_range(0, 19);
         if (dt_kind == 0) begin
            dt = '0;
         end else if (dt_kind == 1) begin
            dt = TIME_MAX;
         end else begin
            dt = 16'($urandom_range(0, dt_cap));
         end
         if (saturate) begin
            dt = 16'($urandom_range(60000, 65535));
            if (pick < 3) begin
               act = ACT_PRESS;
            end else if (pick < 10) begin
               act  = ACT_MOVE;
               span = span * 7 / 10;
               x = 16'(int'(sb.anchor_x) + int'($urandom_range(0, 2 * span)) - span);
               y = 16'(int'(sb.anchor_y) + int'($urandom_range(0, 2 * span)) - span);
            end
         end else if (pick < 50) begin
            act = $urandom_range(0, 1) ? ACT_PRESS : ACT_RELEASE;
         end else if (pick < 120) begin
            act = action_type'($urandom_range(ACT_MOVE, ACT_OTHER));
            dt  = 16'($urandom);
         end else if (pick < 300) begin
            act = ACT_MOVE;
            if ($urandom_range(0, 1)) begin
               span = span * 7 / 10;
            end else begin
               span = span + 1;
            end
            x = 16'(int'(sb.anchor_x) + int'($urandom_range(0, 2 * span)) - span);
            y = 16'(int'(sb.anchor_y) + int'($urandom_range(0, 2 * span)) - span);
         end else if (pick < 380) begin
            act = ACT_MOVE;
         end
         send_event(act, x, y, dt);
      end
   endtask

   initial begin
      int stall_len;
      wait (!reset);
      forever begin
         stall_len = rx_idle ? $urandom_range(0, 11) : 0;
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_result(rsp_confirmed);
      end
   end

   initial begin
      int required;
      int waited;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_event(ACT_OTHER, 16'sd0, 16'sd0, TIME_MAX);
      send_event(ACT_MOVE, 16'sd0, 16'sd0, 16'd0);
      send_event(ACT_MOVE, 16'sd3, 16'sd4, 16'd499);
      send_event(ACT_OTHER, 16'sh1234, -16'sd77, 16'd1);
      send_event(ACT_MOVE, 16'sd3, 16'sd5, 16'd7);
      send_event(ACT_OTHER, 16'sd0, 16'sd0, 16'd0);
      send_event(ACT_PRESS, 16'sd9, 16'sd9, 16'd300);
      send_event(ACT_OTHER, 16'sd0, 16'sd0, 16'd100);
      send_event(ACT_MOVE, POS_MIN, POS_MIN, 16'd0);
      send_event(ACT_MOVE, POS_MAX, POS_MAX, 16'd0);
      send_event(ACT_MOVE, POS_MAX - 16'sd3, POS_MAX - 16'sd4, TIME_MAX);
      send_event(ACT_RELEASE, POS_MAX, POS_MIN, TIME_MAX);
      send_event(ACT_MOVE, POS_MIN, POS_MAX, 16'd0);
      send_event(ACT_MOVE, POS_MIN + 16'sd3, POS_MAX - 16'sd4, 16'd500);
      send_event(ACT_MOVE, POS_MIN + 16'sd3, POS_MAX - 16'sd5, 16'd0);
      send_event(ACT_OTHER, 16'sh5555, -16'sh5556, 16'hAAAA);
      send_event(ACT_OTHER, -16'sh5556, 16'sh5555, 16'h5555);
      random_events(300, 200, 1'b0);

      apply_reg(CSR_REQUIRED_DWELL, 24'd0);
      apply_reg(CSR_RADIUS, {8'hA5, 16'd0});
      send_event(ACT_PRESS, 16'sd0, 16'sd0, 16'd0);
      send_event(ACT_OTHER, 16'sd0, 16'sd0, 16'd0);
      send_event(ACT_MOVE, 16'sd7, -16'sd7, 16'd0);
      send_event(ACT_OTHER, 16'sd0, 16'sd0, 16'd0);
      send_event(ACT_MOVE, 16'sd7, -16'sd7, 16'd0);
      send_event(ACT_MOVE, 16'sd8, -16'sd7, 16'd0);
      random_events(200, 50, 1'b0);

      apply_reg(CSR_UNUSED_LO, 24'h5A5A5A);
      apply_reg(CSR_UNUSED_HI, DWELL_MAX);
      apply_reg(CSR_REQUIRED_DWELL, DWELL_MAX);
      apply_reg(CSR_RADIUS, {8'($urandom), 16'hFFFF});
      send_event(ACT_MOVE, POS_MIN, POS_MIN, 16'd0);
      send_event(ACT_MOVE, POS_MAX, POS_MAX, 16'd0);
      random_events(400, 0, 1'b1);

      for (int p = 0; p < 3; p++) begin
         required = $urandom_range(1, 3000);
         apply_reg(CSR_REQUIRED_DWELL, 24'(required));
         apply_reg(CSR_RADIUS, {8'($urandom), 16'($urandom_range(0, 60))});
         random_events(280, required / 3 + 1, 1'b0);
      end

      apply_reg(CSR_REQUIRED_DWELL, 24'($urandom));
      apply_reg(CSR_RADIUS, 24'($urandom));
      random_events(200, 65535, 1'b0);

      req_valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      sb.report_leftovers();

      $display("Run covered %0d pointer events, %0d of them confirming hover and %0d %s",
               sb.events, sb.confirms, sb.saturations, "adds that hit the dwell ceiling,");
      $display("with %0d register writes spanning zero and full dwell and radius.",
               settings_written);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
